FILE: rtl/bavg_pkg.sv
`default_nettype none

package bavg_pkg;

  // bins built and field widths
  localparam int NUM_BINS = 64;
  localparam int BIN_W    = 6;
  localparam int DATA_W   = 32;
  localparam int SUM_W    = 64;
  localparam int CNT_W    = 32;
  localparam int ADDR_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int STEP_W   = $clog2(SUM_W);

  // request codes
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_FIN = 1'b1;

  // saturation bounds of a Q16.16 result
  localparam logic [DATA_W-1:0] AVG_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] AVG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FRD,
    ST_FCHK,
    ST_FDIV,
    ST_FPUT
  } state_t;

  // divider command and status
  typedef struct packed {
    logic start;
    logic neg;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bavg_ifs.sv
`default_nettype none

// request channel: add or finalize item
interface bavg_req_if import bavg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [BIN_W-1:0]         bin_index;
  logic signed [DATA_W-1:0] sample_value;

  modport source (output valid, req_type, bin_index, sample_value, input ready);
  modport sink (input valid, req_type, bin_index, sample_value, output ready);
endinterface

// result channel: one item per bin
interface bavg_rsp_if import bavg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BIN_W-1:0]         out_bin;
  logic signed [DATA_W-1:0] average_value;
  logic                     bin_defined;
  logic                     last_result;

  modport source (output valid, out_bin, average_value, bin_defined, last_result,
                  input ready);
  modport sink (input valid, out_bin, average_value, bin_defined, last_result,
                output ready);
endinterface

// configuration write channel
interface bavg_cfg_if import bavg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] undefined_value;

  modport source (output valid, undefined_value, input ready);
  modport sink (input valid, undefined_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/bavg_div.sv
`default_nettype none

module bavg_div import bavg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_cmd_t         cmd,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output div_sts_t         sts
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic              neg;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic              pos_ovf;
  logic              neg_ovf;
  logic [DATA_W-1:0] result;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  // control: busy until every dividend bit is shifted through, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      neg <= cmd.neg;
    end else if (busy) begin
      rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  // sign and saturation of the magnitude quotient
  assign pos_ovf = |quo[SUM_W-1:DATA_W-1];
  assign neg_ovf = (|quo[SUM_W-1:DATA_W]) || (quo[DATA_W-1] && (|quo[DATA_W-2:0]));

  always_comb begin
    if (neg) begin
      result = neg_ovf ? AVG_MIN : (~quo[DATA_W-1:0] + DATA_W'(1));
    end else begin
      result = pos_ovf ? AVG_MAX : quo[DATA_W-1:0];
    end
  end

  assign sts.done     = done;
  assign sts.quotient = result;

endmodule

`default_nettype wire

FILE: rtl/binned_average_accumulator_unit.sv
// add item: memory read, then update and write back in ST_ADD; ready returns after it
// finalize item: a bin with samples is read (ST_FRD, ST_FCHK), divided bit-serially (ST_FDIV)
//   and put out (ST_FPUT); an empty bin skips the divide; results come in bin order
// throughput is bound by the shared bit-serial divider, one quotient bit a cycle
// a result waits in the output register while the next bin is worked on
// reset: synchronous, clears the per-bin valid bits (all sums and counts read zero),
//   the undefined value and all control; no clearing pass

`default_nettype none

module binned_average_accumulator_unit import bavg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bavg_req_if.sink    req,
  bavg_rsp_if.source  rsp,
  bavg_cfg_if.sink    cfg
);

  state_t state, state_next;

  logic [DATA_W-1:0] undefined_value;

  // latched add item
  logic [ADDR_W-1:0] add_bin;
  logic              add_ok;
  logic [DATA_W-1:0] add_sample;

  // finalize walk
  logic [ADDR_W-1:0] fin_bin;
  logic              fin_last;

  // bin stores
  logic [SUM_W-1:0]  sum_mem [NUM_BINS];
  logic [CNT_W-1:0]  cnt_mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_vld;
  logic [SUM_W-1:0]  cur_sum;
  logic [CNT_W-1:0]  cur_cnt;
  logic              wr_en;
  logic [SUM_W-1:0]  new_sum;
  logic [CNT_W-1:0]  new_cnt;

  // divider
  div_cmd_t          div_cmd;
  div_sts_t          div_sts;
  logic [SUM_W-1:0]  div_mag;

  // result of the current bin
  logic [DATA_W-1:0] res_avg;
  logic              res_def;

  // output register
  logic              out_valid;
  logic [BIN_W-1:0]  out_bin;
  logic [DATA_W-1:0] out_avg;
  logic              out_def;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  logic              req_acc;

  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      undefined_value <= '0;
    end else if (cfg.valid && cfg.ready) begin
      undefined_value <= cfg.undefined_value;
    end
  end

  // store read and write
  assign rd_addr = (state == ST_IDLE) ? req.bin_index[ADDR_W-1:0] : fin_bin;
  assign cur_sum = rd_vld ? rd_sum : '0;
  assign cur_cnt = rd_vld ? rd_cnt : '0;
  assign wr_en   = (state == ST_ADD) && add_ok && (cur_cnt != '1);
  assign new_sum = cur_sum + {{(SUM_W-DATA_W){add_sample[DATA_W-1]}}, add_sample};
  assign new_cnt = cur_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    rd_sum <= sum_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
    if (wr_en) begin
      sum_mem[add_bin] <= new_sum;
      cnt_mem[add_bin] <= new_cnt;
    end
  end

  // per-bin valid bits, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[add_bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[rd_addr];
  end

  // magnitude of the sum for the divider
  assign div_mag = cur_sum[SUM_W-1] ? (~cur_sum + SUM_W'(1)) : cur_sum;

  bavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_mag),
    .divisor  (cur_cnt),
    .sts      (div_sts)
  );

  assign fin_last = (fin_bin == ADDR_W'(NUM_BINS - 1));
  assign out_free = !out_valid || rsp.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next    = state;
    div_cmd.start = 1'b0;
    div_cmd.neg   = cur_sum[SUM_W-1];
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = (req.req_type == REQ_FIN) ? ST_FRD : ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ST_IDLE;
      end
      ST_FRD: begin
        state_next = ST_FCHK;
      end
      ST_FCHK: begin
        if (cur_cnt != '0) begin
          div_cmd.start = 1'b1;
          state_next    = ST_FDIV;
        end else begin
          state_next = ST_FPUT;
        end
      end
      ST_FDIV: begin
        if (div_sts.done) begin
          state_next = ST_FPUT;
        end
      end
      ST_FPUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = fin_last ? ST_IDLE : ST_FRD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item latch, bin walk and per-bin result
  always_ff @(posedge clk) begin
    if (req_acc) begin
      add_bin    <= req.bin_index[ADDR_W-1:0];
      add_ok     <= {1'b0, req.bin_index} < (BIN_W + 1)'(NUM_BINS);
      add_sample <= req.sample_value;
    end
    if (req_acc) begin
      fin_bin <= '0;
    end else if (out_load && !fin_last) begin
      fin_bin <= fin_bin + ADDR_W'(1);
    end
    if (state == ST_FCHK && cur_cnt == '0) begin
      res_avg <= undefined_value;
      res_def <= 1'b0;
    end else if (state == ST_FDIV && div_sts.done) begin
      res_avg <= div_sts.quotient;
      res_def <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin  <= BIN_W'(fin_bin);
      out_avg  <= res_avg;
      out_def  <= res_def;
      out_last <= fin_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.out_bin       = out_bin;
  assign rsp.average_value = out_avg;
  assign rsp.bin_defined   = out_def;
  assign rsp.last_result   = out_last;

endmodule

`default_nettype wire

FILE: rtl/bavg_chk.sv
`default_nettype none

module bavg_chk import bavg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [BIN_W-1:0]  out_bin,
  input logic [DATA_W-1:0] average_value,
  input logic              bin_defined,
  input logic              last_result
);

  logic [BIN_W-1:0] exp_bin;

  // bin expected on the next result item
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_bin <= '0;
    end else if (rsp_valid && rsp_ready) begin
      exp_bin <= last_result ? '0 : exp_bin + BIN_W'(1);
    end
  end

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // results walk the bins in order
  a_bin_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> out_bin == exp_bin)
    else $error("result bin out of order");

  // last mark only on the highest bin
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (last_result == (out_bin == BIN_W'(NUM_BINS - 1))))
    else $error("last mark does not match bin");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_bin) &&
      $stable(average_value) && $stable(bin_defined) && $stable(last_result))
    else $error("stalled result changed");

endmodule

bind binned_average_accumulator_unit bavg_chk u_bavg_chk (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .out_bin       (rsp.out_bin),
  .average_value (rsp.average_value),
  .bin_defined   (rsp.bin_defined),
  .last_result   (rsp.last_result)
);

`default_nettype wire
